>>> rtl/core/bole_pkg.sv
package bole_pkg;

  localparam int CAPACITY_MAX_DEF = 64;
  localparam int WORD_BITS_DEF = 32;

  localparam int CMD_BITS = 3;
  localparam int IDX_BITS = 7;
  localparam int VAL_BITS = 32;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_SELECT  = 3'd2,
    CMD_SEARCH  = 3'd3,
    CMD_REPLACE = 3'd4,
    CMD_RSVD5   = 3'd5,
    CMD_RSVD6   = 3'd6,
    CMD_RSVD7   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HOLD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } sts_t;

endpackage

>>> rtl/core/bounded_ordered_list_engine.sv
// Ordered list of up to CAPACITY_MAX words held in shift-register cells.
// Each command word is first captured, then executed with every cell shifting
// or comparing in parallel; the result word is then held until taken, and the
// next command is captured on that same edge, so a new word is not accepted
// before the previous result is taken. tdata in: command, index, value.
// tdata out: ok, read_value, found_position, entry_count, is_empty, is_full.
module bounded_ordered_list_engine #(
  parameter int CAPACITY_MAX = bole_pkg::CAPACITY_MAX_DEF,
  parameter int WORD_BITS = bole_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // command[2:0], index[9:3], value[41:10], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // ok[0], read_value[32:1], found_position[39:33],
                                // entry_count[46:40], is_empty[47], is_full[48], pad
);
  import bole_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic ok, is_empty, is_full;
  logic [VAL_BITS-1:0] read_value;
  logic [IDX_BITS-1:0] found_position, entry_count;

  bole_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .ctl(ctl), .sts(sts)
  );

  bole_dp #(.CAPACITY_MAX(CAPACITY_MAX), .WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .command(s_tdata[2:0]), .index(s_tdata[9:3]), .value(s_tdata[41:10]),
    .ok(ok), .read_value(read_value), .found_position(found_position),
    .entry_count(entry_count), .is_empty(is_empty), .is_full(is_full)
  );

  assign m_tdata = {7'd0, is_full, is_empty, entry_count, found_position, read_value, ok};

  a_no_load_while_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |-> !ctl.load) else $error("load during exec");
  a_exec_then_result: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |=> m_tvalid) else $error("no result after exec");
  a_empty_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(is_empty && is_full)) else $error("empty and full");

endmodule

>>> rtl/core/bole_ctrl.sv
module bole_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bole_pkg::ctl_t ctl,
  input  bole_pkg::sts_t sts
);
  import bole_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: if (sts.done) state_next = ST_HOLD;
      ST_HOLD: begin
        if (out_ready) state_next = in_valid ? ST_EXEC : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    ctl = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_EXEC: ctl.exec = 1'b1;
      ST_HOLD: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        ctl.load = out_ready && in_valid;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/bole_dp.sv
module bole_dp #(
  parameter int CAPACITY_MAX = bole_pkg::CAPACITY_MAX_DEF,
  parameter int WORD_BITS = bole_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bole_pkg::ctl_t                 ctl,
  output bole_pkg::sts_t                 sts,
  input  logic [bole_pkg::CMD_BITS-1:0]  command,
  input  logic [bole_pkg::IDX_BITS-1:0]  index,
  input  logic [bole_pkg::VAL_BITS-1:0]  value,
  output logic                           ok,
  output logic [bole_pkg::VAL_BITS-1:0]  read_value,
  output logic [bole_pkg::IDX_BITS-1:0]  found_position,
  output logic [bole_pkg::IDX_BITS-1:0]  entry_count,
  output logic                           is_empty,
  output logic                           is_full
);
  import bole_pkg::*;

  localparam int AW = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
  localparam int CW = $clog2(CAPACITY_MAX + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY_MAX);

  // shift-register cells
  logic [WORD_BITS-1:0] cells [CAPACITY_MAX];
  logic [CW-1:0]        occ;
  cmd_t                 cmd_q;
  logic [CW-1:0]        idx_q;
  logic [WORD_BITS-1:0] val_q;

  logic idx_fit;
  assign idx_fit = (index >> CW) == '0;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= cmd_t'(command);
      // out-of-range indexes saturate to a value that fails every range check
      idx_q <= idx_fit ? CW'(index) : {CW{1'b1}};
      val_q <= WORD_BITS'(value);
    end
  end

  logic ins_ok, rem_ok, rep_ok, sel_ok;
  logic [CW-1:0] sel_p;
  always_comb begin
    ins_ok = (idx_q <= occ) && (occ < CAP);
    rem_ok = (idx_q < occ);
    rep_ok = (idx_q < occ);
    sel_ok = (occ != '0);
    sel_p = (idx_q < occ) ? idx_q : occ - 1'b1;
  end

  // per-cell match and last-match priority
  logic [CAPACITY_MAX-1:0] hit;
  always_comb begin
    for (int i = 0; i < CAPACITY_MAX; i++)
      hit[i] = (cells[i] == val_q) && (CW'(i) < occ);
  end
  logic [CW-1:0] last_hit;
  always_comb begin
    last_hit = occ;
    for (int i = 0; i < CAPACITY_MAX; i++)
      if (hit[i]) last_hit = CW'(i);
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      for (int i = 0; i < CAPACITY_MAX; i++) begin
        unique case (cmd_q)
          CMD_INSERT: if (ins_ok) begin
            if (CW'(i) == idx_q) cells[i] <= val_q;
            else if (CW'(i) > idx_q && i > 0) cells[i] <= cells[(i > 0) ? i-1 : 0];
          end
          CMD_REMOVE: if (rem_ok) begin
            if (CW'(i) >= idx_q && i < CAPACITY_MAX-1)
              cells[i] <= cells[(i < CAPACITY_MAX-1) ? i+1 : i];
          end
          CMD_REPLACE: if (rep_ok && CW'(i) == idx_q) cells[i] <= val_q;
          default: ;
        endcase
      end
    end
  end

  logic [CW-1:0] occ_next;
  always_comb begin
    occ_next = occ;
    if (cmd_q == CMD_INSERT && ins_ok) occ_next = occ + 1'b1;
    if (cmd_q == CMD_REMOVE && rem_ok) occ_next = occ - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) occ <= '0;
    else if (ctl.exec) occ <= occ_next;
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      ok <= 1'b0;
      read_value <= '0;
      found_position <= '0;
      unique case (cmd_q)
        CMD_INSERT:  ok <= ins_ok;
        CMD_REMOVE:  ok <= rem_ok;
        CMD_SELECT: begin
          ok <= sel_ok;
          if (sel_ok) read_value <= VAL_BITS'(cells[sel_p[AW-1:0]]);
        end
        CMD_SEARCH: begin
          ok <= 1'b1;
          found_position <= IDX_BITS'(last_hit);
        end
        CMD_REPLACE: ok <= rep_ok;
        default: ok <= 1'b0;
      endcase
      entry_count <= IDX_BITS'(occ_next);
      is_empty <= (occ_next == '0);
      is_full <= (occ_next == CAP);
    end
  end

  assign sts.done = ctl.exec;

endmodule

>>> dv/bounded_ordered_list_engine_test.sv
`timescale 1ns / 1ps

module bounded_ordered_list_engine_test;
  import bole_pkg::*;

  localparam int CAP = CAPACITY_MAX_DEF;

  // packed from the top bit down, so ok lands in bit 0
  typedef struct packed {
    logic        is_full;
    logic        is_empty;
    logic [6:0]  entry_count;
    logic [6:0]  found_position;
    logic [31:0] read_value;
    logic        ok;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  bounded_ordered_list_engine dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  // shadow copy of the list
  logic [31:0]  shadow_list [CAP];
  int           shadow_count;
  list_result_t expected_results [$];
  int           error_count;
  int           words_sent;
  int           results_seen;
  int           send_idle_pct;
  int           take_idle_pct;
  int           cycle_count;

  function automatic list_result_t predict_list_op(cmd_t cmd, int idx, logic [31:0] val);
    list_result_t r;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (idx <= shadow_count && shadow_count < CAP) begin
          for (int i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[idx] = val;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (idx < shadow_count) begin
          for (int i = idx; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
          r.ok = 1'b1;
        end
      end
      CMD_SELECT: begin
        if (shadow_count != 0) begin
          r.read_value = shadow_list[(idx < shadow_count) ? idx : shadow_count - 1];
          r.ok = 1'b1;
        end
      end
      CMD_SEARCH: begin
        r.found_position = 7'(shadow_count);
        for (int i = 0; i < shadow_count; i++)
          if (shadow_list[i] == val) r.found_position = 7'(i);
        r.ok = 1'b1;
      end
      CMD_REPLACE: begin
        if (idx < shadow_count) begin
          shadow_list[idx] = val;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = 7'(shadow_count);
    r.is_empty = (shadow_count == 0);
    r.is_full = (shadow_count == CAP);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
    error_count++;
  endtask

  // drive one command word; valid stays high across back-to-back words
  task automatic send_command(cmd_t cmd, int idx, logic [31:0] val);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, val, 7'(idx), cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(predict_list_op(cmd, idx, val));
    words_sent++;
  endtask

  task automatic go_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    list_result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[48:0];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", m_tdata[31:0], 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.found_position !== want.found_position)
            report_mismatch("found_position", got.found_position, want.found_position);
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", got.entry_count, want.entry_count);
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", got.is_empty, want.is_empty);
          if (got.is_full !== want.is_full)
            report_mismatch("is_full", got.is_full, want.is_full);
        end
        results_seen++;
      end
      m_tready <= !(take_idle_pct > 0 && $urandom_range(99) < take_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 200000) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("bounded_ordered_list_engine_test failed");
      $finish;
    end
  end

  task automatic test_directed_edges();
    // empty list: every command rejected or reports nothing
    send_command(CMD_REMOVE, 0, 32'h0);
    send_command(CMD_SELECT, 0, 32'h0);
    send_command(CMD_SEARCH, 0, 32'hFFFF_FFFF);
    send_command(CMD_REPLACE, 0, 32'h1);
    send_command(CMD_INSERT, 1, 32'h5);           // past count
    send_command(CMD_INSERT, 0, 32'hFFFF_FFFF);   // only entry
    send_command(CMD_REMOVE, 0, 32'h0);           // removes the only entry
    send_command(CMD_INSERT, 0, 32'hAAAA_5555);
    send_command(CMD_INSERT, 1, 32'h5555_AAAA);   // back
    send_command(CMD_INSERT, 1, 32'h0000_0000);   // middle
    send_command(CMD_INSERT, 0, 32'h5555_AAAA);   // dup for last-match search
    send_command(CMD_SEARCH, 0, 32'h5555_AAAA);
    send_command(CMD_SEARCH, 0, 32'h1234_5678);   // miss
    send_command(CMD_SELECT, 127, 32'h0);         // past end gives last
    send_command(CMD_REPLACE, 2, 32'hDEAD_BEEF);
    send_command(CMD_REPLACE, 4, 32'h1);
    send_command(CMD_REMOVE, 1, 32'h0);           // middle removal
    send_command(CMD_REMOVE, 64, 32'h0);
    send_command(CMD_RSVD5, 0, 32'h0);
    send_command(CMD_RSVD6, 127, 32'hFFFF_FFFF);
    send_command(CMD_RSVD7, 3, 32'h0);
    go_quiet();
  endtask

  task automatic test_fill_to_full();
    while (shadow_count < CAP) send_command(CMD_INSERT, $urandom_range(shadow_count), $urandom);
    send_command(CMD_INSERT, 0, 32'h1);           // full
    send_command(CMD_INSERT, 64, 32'h1);
    send_command(CMD_SELECT, 63, 32'h0);
    send_command(CMD_SEARCH, 0, shadow_list[63]);
    go_quiet();   // pause until drained
    while (shadow_count > 0) send_command(CMD_REMOVE, $urandom_range(shadow_count - 1), 32'h0);
    go_quiet();
  endtask

  task automatic test_random_mix(int n);
    int pick, idx;
    logic [31:0] val;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      // narrow value pool so searches hit
      val = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(7));
      idx = (shadow_count == 0 || $urandom_range(9) == 0) ? $urandom_range(127)
            : $urandom_range(shadow_count);
      if (pick < 30 + (shadow_count < 8 ? 20 : 0)) send_command(CMD_INSERT, idx, val);
      else if (pick < 55) send_command(CMD_REMOVE, idx, val);
      else if (pick < 70) send_command(CMD_SELECT, idx, val);
      else if (pick < 85) send_command(CMD_SEARCH, idx, val);
      else if (pick < 97) send_command(CMD_REPLACE, idx, val);
      else send_command(cmd_t'($urandom_range(7, 5)), idx, val);
    end
    go_quiet();
  endtask

  initial begin
    error_count = 0;
    words_sent = 0;
    results_seen = 0;
    cycle_count = 0;
    shadow_count = 0;
    send_idle_pct = 37;
    take_idle_pct = 60;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_fill_to_full();
    test_random_mix(250);
    send_idle_pct = 60;
    take_idle_pct = 37;
    test_random_mix(250);
    send_idle_pct = 0;
    take_idle_pct = 0;
    test_random_mix(250);
    repeat (20) @(posedge clk);
    $display("sent %0d command words, checked %0d results", words_sent, results_seen);
    $display("covered empty, full, reject paths, reserved commands and three idle mixes");
    if (error_count == 0) begin
      $display("bounded_ordered_list_engine_test passed");
    end else begin
      $display("bounded_ordered_list_engine_test failed");
    end
    $finish;
  end

endmodule
